FILE: src/cbm_pkg.sv
// ----------------------------------------------------------------------------
// cbm_pkg
// Shared types and constants for the cartridge bank mapper: request kinds,
// target codes, configuration and mapper register indexes, control bits and geometry.
// ----------------------------------------------------------------------------
`default_nettype none

package cbm_pkg;

  // request kinds carried in s_tuser
  typedef enum logic [1:0] {
    OP_MAP_WR = 2'd0,
    OP_MAP_RD = 2'd1,
    OP_WIN_WR = 2'd2,
    OP_XLATE  = 2'd3
  } op_t;

  // memory targets carried in m_tuser
  typedef enum logic [2:0] {
    TGT_NONE = 3'd0,
    TGT_ROM  = 3'd1,
    TGT_BIOS = 3'd2,
    TGT_RAM  = 3'd3,
    TGT_SYS  = 3'd4
  } tgt_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_BIOS_DIS   = 2'd0,
    CFG_CART_DIS   = 2'd1,
    CFG_ROM_PAGES  = 2'd2,
    CFG_BIOS_PAGES = 2'd3
  } cfg_idx_t;

  // mapper register indexes
  localparam logic [1:0] REG_CTRL  = 2'd0;
  localparam logic [1:0] REG_SLOT0 = 2'd1;
  localparam logic [1:0] REG_SLOT1 = 2'd2;
  localparam logic [1:0] REG_SLOT2 = 2'd3;

  // control register bits
  localparam int CTRL_RAM_BIT  = 3;
  localparam int CTRL_HALF_BIT = 2;

  // geometry
  localparam int RAM_BYTES = 32768;
  localparam int MAX_PAGES = 256;
  localparam int PAGE_BITS = 14;
  localparam int PHYS_W    = 22;
  localparam logic [15:0] LOW_AREA = 16'h0400;

endpackage

`default_nettype wire

FILE: src/cartridge_bank_mapper.sv
// ----------------------------------------------------------------------------
// cartridge_bank_mapper
// 16 KB bank switching mapper for cartridge or BIOS ROM, with cartridge RAM
// mapping into 8000-BFFF. Page numbers come from a shared bit-serial modulo.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake         | payload
//  s_*      | in  | s_tvalid/s_tready | tuser: operation; tdata: address, data
//  m_*      | out | m_tvalid/m_tready | tuser: target; tdata: read_data,
//           |     |                   |   phys_address, ram_write, ram_used
//  cfg_*    | in  | cfg_we            | cfg_addr index, cfg_wdata value
//
//  mapper writes and window writes go through accept, 8 modulo steps
//  in the shared restoring divider, then the commit state
//  reads and translations go through accept and commit only
//  one request in flight; s_tready is high only in the idle state
//  the commit waits while the output register holds an untaken result
//  rst is synchronous and clears mapper state, config and output valid
`default_nettype none

module cartridge_bank_mapper (
  input  wire logic        clk,
  input  wire logic        rst,
  // request in
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [23:0] s_tdata,  // [15:0] address, [23:16] data
  input  wire logic [1:0]  s_tuser,  // [1:0] operation
  // result out
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [31:0] m_tdata,  // [7:0] read_data, [29:8] phys_address,
                                     // [30] ram_write, [31] ram_used
  output      logic [2:0]  m_tuser,  // [2:0] target
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [7:0]  cfg_wdata
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_COMMIT
  } state_t;

  state_t state;

  // configuration
  logic       bios_disabled;
  logic       cart_disabled;
  logic [7:0] rom_pages;
  logic [7:0] bios_pages;

  // mapper state
  logic [7:0] mapper_regs [4];
  logic [7:0] window_pages [3];
  logic       ram_mapped;
  logic       ram_half;
  logic       ram_used_flag;

  // latched request
  cbm_pkg::op_t op;
  logic [15:0]  addr;
  logic [7:0]   data;

  // shared divider
  logic [8:0] rem;
  logic [7:0] dvd;
  logic [2:0] step;

  logic       slot_off;
  logic [7:0] count_sel;
  logic [8:0] divisor;
  logic [8:0] rem_shift;
  logic [8:0] rem_next;
  logic [7:0] page;
  logic       need_mod;
  logic [7:0] dvd_init;
  logic       out_free;

  logic [7:0]          res_rd;
  cbm_pkg::tgt_t       res_tgt;
  logic [21:0]         res_phys;
  logic                res_wr;
  cbm_pkg::tgt_t       src;
  logic [7:0]          ctrl;

  // cartridge RAM address: half plus window offset, wrapped to RAM size
  function automatic logic [21:0] ram_addr(input logic half, input logic [13:0] off);
    logic [16:0] v;
    v = 17'({half, off});
    if (v >= 17'(cbm_pkg::RAM_BYTES)) begin
      v = v - 17'(cbm_pkg::RAM_BYTES);
    end
    return 22'(v);
  endfunction

  assign slot_off  = bios_disabled & cart_disabled;
  assign src       = bios_disabled ? cbm_pkg::TGT_ROM : cbm_pkg::TGT_BIOS;
  assign count_sel = bios_disabled ? rom_pages : bios_pages;
  assign ctrl      = mapper_regs[cbm_pkg::REG_CTRL];
  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == ST_IDLE);

  // page count clamped to the largest supported count
  assign divisor = (9'(count_sel) > 9'(cbm_pkg::MAX_PAGES)) ?
                   9'(cbm_pkg::MAX_PAGES) : 9'(count_sel);

  // one restoring step per cycle
  assign rem_shift = {rem[7:0], dvd[7]};
  assign rem_next  = (rem_shift >= divisor) ? rem_shift - divisor : rem_shift;
  assign page      = (divisor == 9'd0) ? 8'd0 : rem[7:0];

  // writes need a page number; control write pages slot 2 from register 3
  assign need_mod = (cbm_pkg::op_t'(s_tuser) == cbm_pkg::OP_MAP_WR) ||
                    (cbm_pkg::op_t'(s_tuser) == cbm_pkg::OP_WIN_WR);
  assign dvd_init = ((cbm_pkg::op_t'(s_tuser) == cbm_pkg::OP_MAP_WR) &&
                     (s_tdata[1:0] == cbm_pkg::REG_CTRL)) ?
                    mapper_regs[cbm_pkg::REG_SLOT2] : s_tdata[23:16];

  // result fields
  always_comb begin
    res_rd   = 8'd0;
    res_tgt  = cbm_pkg::TGT_NONE;
    res_phys = 22'd0;
    res_wr   = 1'b0;
    case (op)
      cbm_pkg::OP_MAP_RD: begin
        res_rd = mapper_regs[addr[1:0]];
      end
      cbm_pkg::OP_WIN_WR: begin
        if (ctrl[cbm_pkg::CTRL_RAM_BIT]) begin
          res_tgt  = cbm_pkg::TGT_RAM;
          res_phys = ram_addr(ctrl[cbm_pkg::CTRL_HALF_BIT], addr[13:0]);
          res_wr   = 1'b1;
        end
      end
      cbm_pkg::OP_XLATE: begin
        if (addr[15:14] == 2'b11) begin
          res_tgt  = cbm_pkg::TGT_SYS;
          res_phys = 22'(addr);
        end else if (slot_off) begin
          res_tgt = cbm_pkg::TGT_NONE;
        end else if (addr < cbm_pkg::LOW_AREA) begin
          res_tgt  = src;
          res_phys = 22'(addr);
        end else if (addr[15:14] == 2'b00) begin
          res_tgt  = src;
          res_phys = {window_pages[0], addr[13:0]};
        end else if (addr[15:14] == 2'b01) begin
          res_tgt  = src;
          res_phys = {window_pages[1], addr[13:0]};
        end else if (ram_mapped) begin
          res_tgt  = cbm_pkg::TGT_RAM;
          res_phys = ram_addr(ram_half, addr[13:0]);
        end else begin
          res_tgt  = src;
          res_phys = {window_pages[2], addr[13:0]};
        end
      end
      default: begin
      end
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bios_disabled <= 1'b0;
      cart_disabled <= 1'b0;
      rom_pages     <= 8'd0;
      bios_pages    <= 8'd0;
    end else if (cfg_we) begin
      case (cbm_pkg::cfg_idx_t'(cfg_addr))
        cbm_pkg::CFG_BIOS_DIS:   bios_disabled <= cfg_wdata[0];
        cbm_pkg::CFG_CART_DIS:   cart_disabled <= cfg_wdata[0];
        cbm_pkg::CFG_ROM_PAGES:  rom_pages     <= cfg_wdata;
        cbm_pkg::CFG_BIOS_PAGES: bios_pages    <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // sequencer, mapper state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_tvalid      <= 1'b0;
      ram_mapped    <= 1'b0;
      ram_half      <= 1'b0;
      ram_used_flag <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        mapper_regs[i] <= 8'd0;
      end
      for (int i = 0; i < 3; i++) begin
        window_pages[i] <= 8'd0;
      end
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            op   <= cbm_pkg::op_t'(s_tuser);
            addr <= s_tdata[15:0];
            data <= s_tdata[23:16];
            rem  <= 9'd0;
            dvd  <= dvd_init;
            step <= 3'd0;
            state <= need_mod ? ST_DIV : ST_COMMIT;
          end
        end
        ST_DIV: begin
          rem  <= rem_next;
          dvd  <= {dvd[6:0], 1'b0};
          step <= step + 3'd1;
          if (step == 3'd7) begin
            state <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          if (out_free) begin
            // update mapper state
            if (op == cbm_pkg::OP_MAP_WR) begin
              mapper_regs[addr[1:0]] <= data;
              if (!slot_off) begin
                case (addr[1:0])
                  cbm_pkg::REG_CTRL: begin
                    if (data[cbm_pkg::CTRL_RAM_BIT]) begin
                      ram_mapped    <= 1'b1;
                      ram_used_flag <= 1'b1;
                      ram_half      <= data[cbm_pkg::CTRL_HALF_BIT];
                    end else begin
                      ram_mapped      <= 1'b0;
                      window_pages[2] <= page;
                    end
                  end
                  cbm_pkg::REG_SLOT0: window_pages[0] <= page;
                  cbm_pkg::REG_SLOT1: window_pages[1] <= page;
                  default: begin
                    if (!ctrl[cbm_pkg::CTRL_RAM_BIT]) begin
                      window_pages[2] <= page;
                    end
                  end
                endcase
              end
            end else if (op == cbm_pkg::OP_WIN_WR) begin
              if (!ctrl[cbm_pkg::CTRL_RAM_BIT] && addr == 16'd0 && !slot_off) begin
                window_pages[2] <= page;
                ram_mapped      <= 1'b0;
              end
            end
            // load result; used flag reflects this request's update
            m_tvalid      <= 1'b1;
            m_tuser       <= res_tgt;
            m_tdata[7:0]  <= res_rd;
            m_tdata[29:8] <= res_phys;
            m_tdata[30]   <= res_wr;
            m_tdata[31]   <= ram_used_flag ||
                             (op == cbm_pkg::OP_MAP_WR && !slot_off &&
                              addr[1:0] == cbm_pkg::REG_CTRL &&
                              data[cbm_pkg::CTRL_RAM_BIT]);
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: src/cbm_checker.sv
// ----------------------------------------------------------------------------
// cbm_checker
// Port-level checks for the cartridge bank mapper, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cbm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic [2:0]  m_tuser
);

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // one request in flight: busy after each accepted request
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while busy");

  // nothing addressed means no address and no write
  a_none: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == cbm_pkg::TGT_NONE |-> m_tdata[30:8] == 23'd0)
    else $error("address or write without target");

  // a RAM write always targets cartridge RAM
  a_ram_wr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[30] |-> m_tuser == cbm_pkg::TGT_RAM)
    else $error("RAM write with wrong target");

endmodule

bind cartridge_bank_mapper cbm_checker u_cbm_checker (.*);

`default_nettype wire
